[src/acpi_s5_sleep_type_scan_core_defines.svh]
// Assertion macros used by the parse state machine of the sleep type scanner.
`ifndef ACPI_S5_SLEEP_TYPE_SCAN_CORE_DEFINES_SVH
`define ACPI_S5_SLEEP_TYPE_SCAN_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define AS5_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("as5 same-cycle check failed");

`define AS5_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("as5 next-cycle check failed");

`else

`define AS5_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define AS5_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/as5_pkg.sv]
// Shared opcodes and types of the sleep type scanner.
`timescale 1ns / 1ps

package as5_pkg;

	localparam logic [7:0] OP_NAME       = 8'h08;
	localparam logic [7:0] OP_ROOT       = 8'h5C;
	localparam logic [7:0] OP_PACKAGE    = 8'h12;
	localparam logic [7:0] OP_ZERO       = 8'h00;
	localparam logic [7:0] OP_ONE        = 8'h01;
	localparam logic [7:0] OP_BYTE       = 8'h0A;
	localparam logic [7:0] OP_WORD       = 8'h0B;
	localparam logic [7:0] CHAR_USCORE   = 8'h5F;
	localparam logic [7:0] CHAR_S        = 8'h53;
	localparam logic [7:0] CHAR_FIVE     = 8'h35;
	localparam logic [7:0] TYPE_MAX      = 8'h07;

	typedef struct packed {
		logic       found;
		logic [2:0] sleep_type;
	} result_t;

endpackage

[src/as5_in_if.sv]
// Byte stream channel into the scanner.
`timescale 1ns / 1ps

interface as5_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[src/as5_out_if.sv]
// Result channel out of the scanner.
`timescale 1ns / 1ps

interface as5_out_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [2:0] sleep_type;

	modport source (output valid, output found, output sleep_type, input ready);
	modport sink (input valid, input found, input sleep_type, output ready);
endinterface

[src/as5_parser.sv]
// Input register and AML parse state machine of the scanner.
`timescale 1ns / 1ps
`include "acpi_s5_sleep_type_scan_core_defines.svh"

module as5_parser (
	input  logic             clk,
	input  logic             arst_n,
	as5_in_if.sink           stream,
	input  logic             slot_free,
	output logic             load,
	output as5_pkg::result_t res
);

	typedef enum logic [3:0] {
		PH_SEARCH = 4'd0,
		PH_NAME   = 4'd1,
		PH_ROOT   = 4'd2,
		PH_U1     = 4'd3,
		PH_S      = 4'd4,
		PH_FIVE   = 4'd5,
		PH_U2     = 4'd6,
		PH_LEAD   = 4'd7,
		PH_SKIP   = 4'd8,
		PH_COUNT  = 4'd9,
		PH_ELEM   = 4'd10,
		PH_BYTEV  = 4'd11,
		PH_WLO    = 4'd12,
		PH_WHI    = 4'd13,
		PH_DONE   = 4'd14
	} phase_t;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	phase_t     phase_q, phase_d;
	logic [1:0] left_q, left_d;
	logic [7:0] low_q, low_d;
	logic       made_q, made_d;
	logic       found_q, found_d;
	logic [2:0] value_q, value_d;

	logic       adv;

	function automatic phase_t restart(input logic [7:0] b);
		phase_t p;
		p = (b == as5_pkg::OP_NAME) ? PH_NAME : PH_SEARCH;
		return p;
	endfunction

	assign adv          = valid_s1 && (!last_s1 || slot_free);
	assign stream.ready = !valid_s1 || adv;
	assign load         = adv && last_s1;

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		low_d   = low_q;
		made_d  = made_q;
		found_d = found_q;
		value_d = value_q;
		unique case (phase_q)
			PH_SEARCH: phase_d = restart(byte_s1);
			PH_NAME: begin
				if (byte_s1 == as5_pkg::OP_ROOT)
					phase_d = PH_ROOT;
				else if (byte_s1 == as5_pkg::CHAR_USCORE)
					phase_d = PH_S;
				else
					phase_d = restart(byte_s1);
			end
			PH_ROOT: phase_d = (byte_s1 == as5_pkg::CHAR_USCORE) ? PH_S : restart(byte_s1);
			PH_S:    phase_d = (byte_s1 == as5_pkg::CHAR_S) ? PH_FIVE : restart(byte_s1);
			PH_FIVE: phase_d = (byte_s1 == as5_pkg::CHAR_FIVE) ? PH_U2 : restart(byte_s1);
			PH_U2:   phase_d = (byte_s1 == as5_pkg::CHAR_USCORE) ? PH_U1 : restart(byte_s1);
			PH_U1:   phase_d = (byte_s1 == as5_pkg::OP_PACKAGE) ? PH_LEAD : restart(byte_s1);
			PH_LEAD: begin
				left_d  = byte_s1[7:6];
				phase_d = (byte_s1[7:6] != 2'd0) ? PH_SKIP : PH_COUNT;
			end
			PH_SKIP: begin
				left_d = left_q - 2'd1;
				if (left_q == 2'd1)
					phase_d = PH_COUNT;
			end
			PH_COUNT: begin
				if (byte_s1 == 8'd0) begin
					made_d  = 1'b1;
					found_d = 1'b0;
					value_d = 3'd0;
					phase_d = PH_DONE;
				end else begin
					phase_d = PH_ELEM;
				end
			end
			PH_ELEM: begin
				priority if (byte_s1 == as5_pkg::OP_ZERO || byte_s1 == as5_pkg::OP_ONE) begin
					made_d  = 1'b1;
					found_d = 1'b1;
					value_d = {2'd0, byte_s1[0]};
					phase_d = PH_DONE;
				end else if (byte_s1 == as5_pkg::OP_BYTE) begin
					phase_d = PH_BYTEV;
				end else if (byte_s1 == as5_pkg::OP_WORD) begin
					phase_d = PH_WLO;
				end else begin
					made_d  = 1'b1;
					found_d = 1'b0;
					value_d = 3'd0;
					phase_d = PH_DONE;
				end
			end
			PH_BYTEV: begin
				made_d  = 1'b1;
				found_d = (byte_s1 <= as5_pkg::TYPE_MAX);
				value_d = (byte_s1 <= as5_pkg::TYPE_MAX) ? byte_s1[2:0] : 3'd0;
				phase_d = PH_DONE;
			end
			PH_WLO: begin
				low_d   = byte_s1;
				phase_d = PH_WHI;
			end
			PH_WHI: begin
				made_d  = 1'b1;
				found_d = (byte_s1 == 8'd0) && (low_q <= as5_pkg::TYPE_MAX);
				value_d = ((byte_s1 == 8'd0) && (low_q <= as5_pkg::TYPE_MAX)) ?
					low_q[2:0] : 3'd0;
				phase_d = PH_DONE;
			end
			PH_DONE: phase_d = PH_DONE;
			default: phase_d = PH_DONE;
		endcase
	end

	assign res.found      = made_d && found_d;
	assign res.sleep_type = (made_d && found_d) ? value_d : 3'd0;

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.data_byte;
			last_s1 <= stream.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_SEARCH;
			left_q   <= 2'd0;
			low_q    <= 8'd0;
			made_q   <= 1'b0;
			found_q  <= 1'b0;
			value_q  <= 3'd0;
		end else begin
			if (stream.ready)
				valid_s1 <= stream.valid;
			if (adv) begin
				if (last_s1) begin
					phase_q <= PH_SEARCH;
					left_q  <= 2'd0;
					low_q   <= 8'd0;
					made_q  <= 1'b0;
					found_q <= 1'b0;
					value_q <= 3'd0;
				end else begin
					phase_q <= phase_d;
					left_q  <= left_d;
					low_q   <= low_d;
					made_q  <= made_d;
					found_q <= found_d;
					value_q <= value_d;
				end
			end
		end
	end

	`AS5_ASSERT_NEXT(a_restart_after_last, clk, arst_n, load, phase_q == PH_SEARCH && !made_q)
	`AS5_ASSERT_SAME(a_decision_is_final, clk, arst_n, made_q, phase_q == PH_DONE)
	`AS5_ASSERT_SAME(a_value_needs_found, clk, arst_n, value_q != 3'd0, found_q && made_q)
	`AS5_ASSERT_SAME(a_skip_count_in_skip, clk, arst_n, left_q != 2'd0, phase_q == PH_SKIP)

endmodule

[src/as5_out_reg.sv]
// Result register that drives the output channel.
`timescale 1ns / 1ps

module as5_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  as5_pkg::result_t res,
	output logic             slot_free,
	as5_out_if.source        result
);

	logic             valid_q;
	as5_pkg::result_t res_q;

	assign slot_free         = !valid_q || result.ready;
	assign result.valid      = valid_q;
	assign result.found      = res_q.found;
	assign result.sleep_type = res_q.sleep_type;

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

[src/acpi_s5_sleep_type_scan_core.sv]
// Top level of the scanner that extracts the S5 sleep type from an AML image.
//
//   channel   modport   payload                 role
//   stream    sink      data_byte, last_byte    one image byte per transfer
//   result    source    found, sleep_type       one transfer per image
//
// Bytes are accepted back to back with no gaps unless the final byte of an image waits.
// A byte passes an input register, then updates the parse state machine.
// The result is written to the output register when the final byte is parsed.
// The final byte waits in the input register only while an earlier result is untaken.
// Reset clears all parse state at once; no clearing pass is needed.
`timescale 1ns / 1ps

module acpi_s5_sleep_type_scan_core (
	input  logic      clk,
	input  logic      arst_n,
	as5_in_if.sink    stream,
	as5_out_if.source result
);

	logic             slot_free;
	logic             load;
	as5_pkg::result_t res;

	as5_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream),
		.slot_free (slot_free),
		.load      (load),
		.res       (res)
	);

	as5_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res       (res),
		.slot_free (slot_free),
		.result    (result)
	);

endmodule
